// ----- src/pce_pkg.sv -----
// pce_pkg: shared types, codes and constants of the pci config enumerator
// used by pci_config_enumerator and by tb_top
// no dependencies
`default_nettype none

package pce_pkg;

   // default scan extent
   localparam int DEF_NUM_BUSES = 256;
   localparam int DEF_NUM_SLOTS = 32;

   // result queue depth (two beats per completion plus slack)
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // mechanism-1 address pieces
   localparam logic [31:0] ENABLE_BIT    = 32'h8000_0000;
   localparam logic [7:0]  OFFSET_MASK   = 8'hFC;
   localparam logic [7:0]  OFFSET_IDENT  = 8'h00;
   localparam logic [7:0]  OFFSET_CLASS  = 8'h08;
   localparam logic [7:0]  OFFSET_HEADER = 8'h0E;

   // absent function marker and multi-function flag position
   localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
   localparam int          MULTI_BIT     = 7;
   localparam logic [2:0]  LAST_FUNCTION = 3'd7;

   // input command codes
   localparam logic CMD_START    = 1'b0;
   localparam logic CMD_COMPLETE = 1'b1;

   // result kinds
   typedef enum logic [1:0] {
      KIND_REQUEST = 2'd0,
      KIND_RECORD  = 2'd1,
      KIND_DONE    = 2'd2
   } kind_type;

   // which dword the outstanding read returns
   typedef enum logic [1:0] {
      PHASE_IDENT  = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_CLASS  = 2'd2
   } phase_type;

   // one result beat
   typedef struct packed {
      kind_type    kind;
      logic [31:0] config_address;
      logic [7:0]  bus_number;
      logic [4:0]  slot_number;
      logic [2:0]  function_number;
      logic [15:0] vendor_ident;
      logic [15:0] device_ident;
      logic [7:0]  class_value;
      logic [7:0]  subclass_value;
      logic [7:0]  interface_value;
      logic [7:0]  header_value;
      logic        last;
   } result_type;

   // mechanism-1 address word
   function automatic logic [31:0] make_address(input logic [7:0] bus,
                                                input logic [4:0] slot,
                                                input logic [2:0] func,
                                                input logic [7:0] offset);
      make_address = ENABLE_BIT | {8'd0, bus, slot, func, offset & OFFSET_MASK};
   endfunction

   // read request beat
   function automatic result_type make_request(input logic [7:0] bus,
                                               input logic [4:0] slot,
                                               input logic [2:0] func,
                                               input logic [7:0] offset);
      result_type r;
      r                = '0;
      r.kind           = KIND_REQUEST;
      r.config_address = make_address(bus, slot, func, offset);
      r.last           = 1'b1;
      make_request     = r;
   endfunction

endpackage

`default_nettype wire

// ----- src/pce_req_if.sv -----
// pce_req_if: input channel of the pci config enumerator (start / completion)
// no dependencies
`default_nettype none

interface pce_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] read_data;

   modport source (output valid, output cmd, output read_data, input ready);
   modport sink   (input valid, input cmd, input read_data, output ready);
endinterface

`default_nettype wire

// ----- src/pce_rsp_if.sv -----
// pce_rsp_if: result channel of the pci config enumerator
// (read requests, device records, done marker); no dependencies
`default_nettype none

interface pce_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] config_address;
   logic [7:0]  bus_number;
   logic [4:0]  slot_number;
   logic [2:0]  function_number;
   logic [15:0] vendor_ident;
   logic [15:0] device_ident;
   logic [7:0]  class_value;
   logic [7:0]  subclass_value;
   logic [7:0]  interface_value;
   logic [7:0]  header_value;
   logic        last;

   modport source (output valid, output kind, output config_address, output bus_number,
                   output slot_number, output function_number, output vendor_ident,
                   output device_ident, output class_value, output subclass_value,
                   output interface_value, output header_value, output last,
                   input ready);
   modport sink   (input valid, input kind, input config_address, input bus_number,
                   input slot_number, input function_number, input vendor_ident,
                   input device_ident, input class_value, input subclass_value,
                   input interface_value, input header_value, input last,
                   output ready);
endinterface

`default_nettype wire

// ----- src/pci_config_enumerator.sv -----
// The results of an accepted beat are written into the result queue and offered from its head.
// Throughput: one input beat per cycle while ready is high; a class-dword completion makes two result
// beats, so the rate is bounded by the result side draining one beat per cycle.
// Ready drops when the 4-entry result queue cannot take two more beats.
// Reset (synchronous, active high) clears the scan state and empties the queue.
// Depends on pce_pkg, pce_req_if and pce_rsp_if.
`default_nettype none

module pci_config_enumerator #(
   parameter int NUM_BUSES = pce_pkg::DEF_NUM_BUSES,
   parameter int NUM_SLOTS = pce_pkg::DEF_NUM_SLOTS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pce_req_if.sink    req,
   pce_rsp_if.source  rsp
);

   localparam logic [8:0] BUS_LIMIT  = 9'(NUM_BUSES);
   localparam logic [5:0] SLOT_LIMIT = 6'(NUM_SLOTS);

   // scan state
   logic                 busy_ff, busy_in;
   logic [7:0]           bus_ff, bus_in;
   logic [4:0]           slot_ff, slot_in;
   logic [2:0]           func_ff, func_in;
   pce_pkg::phase_type   phase_ff, phase_in;
   logic                 multi_ff, multi_in;
   logic [31:0]          ident_ff, ident_in;
   logic [7:0]           header_ff, header_in;

   // result queue
   pce_pkg::result_type                       queue_ff [pce_pkg::QUEUE_DEPTH];
   logic [pce_pkg::QUEUE_PTR_W-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [pce_pkg::QUEUE_CNT_W-1:0]           count_ff;

   logic                 accept;
   logic                 pop;
   logic [1:0]           push_cnt;
   pce_pkg::result_type  res0, res1, next_res, head;

   // advance to the next location
   logic                 adv_multi_src;
   logic                 adv_more;
   logic [7:0]           adv_bus;
   logic [4:0]           adv_slot;
   logic [2:0]           adv_func;
   logic                 adv_multi;

   assign accept = req.valid & req.ready;
   assign pop    = rsp.valid & rsp.ready;

   // absent function 0 clears the multi-function flag before stepping
   assign adv_multi_src = (phase_ff != pce_pkg::PHASE_CLASS && func_ff == 3'd0) ?
                          1'b0 : multi_ff;

   always_comb begin
      adv_more  = 1'b1;
      adv_bus   = bus_ff;
      adv_slot  = slot_ff;
      adv_func  = func_ff;
      adv_multi = adv_multi_src;
      if (adv_multi_src && func_ff != pce_pkg::LAST_FUNCTION) begin
         adv_func = func_ff + 3'd1;
      end else begin
         adv_func  = 3'd0;
         adv_multi = 1'b0;
         if (({1'b0, slot_ff} + 6'd1) < SLOT_LIMIT) begin
            adv_slot = slot_ff + 5'd1;
         end else begin
            adv_slot = 5'd0;
            if (({1'b0, bus_ff} + 9'd1) < BUS_LIMIT) begin
               adv_bus = bus_ff + 8'd1;
            end else begin
               adv_bus  = 8'd0;
               adv_more = 1'b0;
            end
         end
      end
   end

   // request for the next location, or the done marker
   always_comb begin
      if (adv_more) begin
         next_res = pce_pkg::make_request(adv_bus, adv_slot, adv_func,
                                          pce_pkg::OFFSET_IDENT);
      end else begin
         next_res      = '0;
         next_res.kind = pce_pkg::KIND_DONE;
         next_res.last = 1'b1;
      end
   end

   // per-beat processing
   always_comb begin
      busy_in   = busy_ff;
      bus_in    = bus_ff;
      slot_in   = slot_ff;
      func_in   = func_ff;
      phase_in  = phase_ff;
      multi_in  = multi_ff;
      ident_in  = ident_ff;
      header_in = header_ff;
      res0      = '0;
      res1      = '0;
      push_cnt  = 2'd0;
      if (accept) begin
         if (req.cmd == pce_pkg::CMD_START) begin
            busy_in   = 1'b1;
            bus_in    = 8'd0;
            slot_in   = 5'd0;
            func_in   = 3'd0;
            phase_in  = pce_pkg::PHASE_IDENT;
            multi_in  = 1'b0;
            ident_in  = 32'd0;
            header_in = 8'd0;
            res0      = pce_pkg::make_request(8'd0, 5'd0, 3'd0, pce_pkg::OFFSET_IDENT);
            push_cnt  = 2'd1;
         end else if (busy_ff) begin
            case (phase_ff)
               pce_pkg::PHASE_HEADER: begin
                  header_in = req.read_data[23:16];
                  if (func_ff == 3'd0) begin
                     multi_in = req.read_data[16 + pce_pkg::MULTI_BIT];
                  end
                  phase_in = pce_pkg::PHASE_CLASS;
                  res0     = pce_pkg::make_request(bus_ff, slot_ff, func_ff,
                                                   pce_pkg::OFFSET_CLASS);
                  push_cnt = 2'd1;
               end
               pce_pkg::PHASE_CLASS: begin
                  res0.kind            = pce_pkg::KIND_RECORD;
                  res0.bus_number      = bus_ff;
                  res0.slot_number     = slot_ff;
                  res0.function_number = func_ff;
                  res0.vendor_ident    = ident_ff[15:0];
                  res0.device_ident    = ident_ff[31:16];
                  res0.class_value     = req.read_data[31:24];
                  res0.subclass_value  = req.read_data[23:16];
                  res0.interface_value = req.read_data[15:8];
                  res0.header_value    = header_ff;
                  res0.last            = 1'b0;
                  res1      = next_res;
                  push_cnt  = 2'd2;
                  busy_in   = adv_more;
                  bus_in    = adv_bus;
                  slot_in   = adv_slot;
                  func_in   = adv_func;
                  multi_in  = adv_multi;
                  phase_in  = pce_pkg::PHASE_IDENT;
               end
               default: begin
                  // vendor/device dword; the unused phase code lands here too
                  ident_in = req.read_data;
                  if (req.read_data[15:0] == pce_pkg::VENDOR_ABSENT) begin
                     res0     = next_res;
                     push_cnt = 2'd1;
                     busy_in  = adv_more;
                     bus_in   = adv_bus;
                     slot_in  = adv_slot;
                     func_in  = adv_func;
                     multi_in = adv_multi;
                     phase_in = pce_pkg::PHASE_IDENT;
                  end else begin
                     phase_in = pce_pkg::PHASE_HEADER;
                     res0     = pce_pkg::make_request(bus_ff, slot_ff, func_ff,
                                                      pce_pkg::OFFSET_HEADER);
                     push_cnt = 2'd1;
                  end
               end
            endcase
         end
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         bus_ff    <= 8'd0;
         slot_ff   <= 5'd0;
         func_ff   <= 3'd0;
         phase_ff  <= pce_pkg::PHASE_IDENT;
         multi_ff  <= 1'b0;
         ident_ff  <= 32'd0;
         header_ff <= 8'd0;
      end else begin
         busy_ff   <= busy_in;
         bus_ff    <= bus_in;
         slot_ff   <= slot_in;
         func_ff   <= func_in;
         phase_ff  <= phase_in;
         multi_ff  <= multi_in;
         ident_ff  <= ident_in;
         header_ff <= header_in;
      end
   end

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + pce_pkg::QUEUE_PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + pce_pkg::QUEUE_PTR_W'(pop);
         count_ff  <= count_ff + pce_pkg::QUEUE_CNT_W'(push_cnt)
                      - pce_pkg::QUEUE_CNT_W'(pop);
      end
   end

   // queue storage, up to two beats written per cycle
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + pce_pkg::QUEUE_PTR_W'(1)] <= res1;
      end
   end

   // handshake: take a beat only when two queue entries are free
   assign req.ready = (count_ff <= pce_pkg::QUEUE_CNT_W'(pce_pkg::QUEUE_DEPTH - 2));
   assign rsp.valid = (count_ff != '0);

   // head of queue to the result channel
   assign head                = queue_ff[rd_ptr_ff];
   assign rsp.kind            = head.kind;
   assign rsp.config_address  = head.config_address;
   assign rsp.bus_number      = head.bus_number;
   assign rsp.slot_number     = head.slot_number;
   assign rsp.function_number = head.function_number;
   assign rsp.vendor_ident    = head.vendor_ident;
   assign rsp.device_ident    = head.device_ident;
   assign rsp.class_value     = head.class_value;
   assign rsp.subclass_value  = head.subclass_value;
   assign rsp.interface_value = head.interface_value;
   assign rsp.header_value    = head.header_value;
   assign rsp.last            = head.last;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for pci_config_enumerator, with a scan predictor,
// a table of hand-checked beats and restarted scans with random content
// depends on pce_pkg, pce_req_if, pce_rsp_if and pci_config_enumerator

module tb_top;
   import pce_pkg::*;

   localparam int NUM_BUSES = DEF_NUM_BUSES;
   localparam int NUM_SLOTS = DEF_NUM_SLOTS;
   localparam int RESTART_ITEMS = 1350;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;
   localparam int MAX_REPORTS = 50;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHECK_PREDICT,
      CHECK_NONE,
      CHECK_REQUEST
   } row_check_type;

   typedef struct packed {
      row_check_type check;
      logic          cmd;
      logic [31:0]   read_data;
      logic [31:0]   address;
   } row_type;

   logic clock = 1'b0;
   logic reset;

   pce_req_if req ();
   pce_rsp_if rsp ();

   pci_config_enumerator #(
      .NUM_BUSES(NUM_BUSES),
      .NUM_SLOTS(NUM_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scan state of the predictor
   logic       scan_busy;
   logic [7:0] scan_bus;
   logic [4:0] scan_slot;
   logic [2:0] scan_func;
   phase_type  scan_phase;
   logic       scan_multi;
   logic [31:0] held_ident;
   logic [7:0] held_header;

   result_type step_beats[$];
   result_type awaited_beats[$];
   row_type    directed_rows[0:20];

   bit failed;
   bit calm;
   int mismatch_count;
   int item_count;
   int quiet_cycles;
   int stall_left;

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic result_type read_request(input logic [7:0] offset);
      result_type beat;
      beat = '0;
      beat.kind = KIND_REQUEST;
      beat.config_address = ENABLE_BIT | {8'd0, scan_bus, scan_slot, scan_func,
                                          offset & OFFSET_MASK};
      beat.last = 1'b1;
      return beat;
   endfunction

   // step to the next function, slot or bus; 0 once the whole scan is covered
   function automatic bit move_to_next_location();
      scan_phase = PHASE_IDENT;
      if (scan_multi && scan_func != LAST_FUNCTION) begin
         scan_func = scan_func + 3'd1;
         return 1'b1;
      end
      scan_func = '0;
      scan_multi = 1'b0;
      if (int'(scan_slot) + 1 < NUM_SLOTS && scan_slot != 5'd31) begin
         scan_slot = scan_slot + 5'd1;
         return 1'b1;
      end
      scan_slot = '0;
      if (int'(scan_bus) + 1 < NUM_BUSES && scan_bus != 8'd255) begin
         scan_bus = scan_bus + 8'd1;
         return 1'b1;
      end
      scan_bus = '0;
      scan_busy = 1'b0;
      return 1'b0;
   endfunction

   // ident read of the next location, or the end-of-scan marker
   function automatic result_type next_location_beat();
      result_type beat;
      if (move_to_next_location()) return read_request(OFFSET_IDENT);
      beat = '0;
      beat.kind = KIND_DONE;
      beat.last = 1'b1;
      return beat;
   endfunction

   // beats caused by one accepted input beat, left in step_beats
   function automatic void predict_enumeration(input logic cmd, input logic [31:0] data);
      result_type record;
      step_beats.delete();
      if (cmd == CMD_START) begin
         scan_bus = '0;
         scan_slot = '0;
         scan_func = '0;
         scan_phase = PHASE_IDENT;
         scan_multi = 1'b0;
         held_ident = '0;
         held_header = '0;
         scan_busy = 1'b1;
         step_beats.push_back(read_request(OFFSET_IDENT));
      end else if (scan_busy) begin
         case (scan_phase)
            PHASE_HEADER: begin
               held_header = data[23:16];
               if (scan_func == '0) scan_multi = held_header[MULTI_BIT];
               scan_phase = PHASE_CLASS;
               step_beats.push_back(read_request(OFFSET_CLASS));
            end
            PHASE_CLASS: begin
               record = '0;
               record.kind = KIND_RECORD;
               record.bus_number = scan_bus;
               record.slot_number = scan_slot;
               record.function_number = scan_func;
               record.vendor_ident = held_ident[15:0];
               record.device_ident = held_ident[31:16];
               record.class_value = data[31:24];
               record.subclass_value = data[23:16];
               record.interface_value = data[15:8];
               record.header_value = held_header;
               step_beats.push_back(record);
               step_beats.push_back(next_location_beat());
            end
            default: begin
               held_ident = data;
               if (data[15:0] == VENDOR_ABSENT) begin
                  if (scan_func == '0) scan_multi = 1'b0;
                  step_beats.push_back(next_location_beat());
               end else begin
                  scan_phase = PHASE_HEADER;
                  step_beats.push_back(read_request(OFFSET_HEADER));
               end
            end
         endcase
      end
   endfunction

   // completion data that fits the outstanding read; absent_pct of ident reads miss
   function automatic logic [31:0] pick_data(input int absent_pct);
      logic [31:0] data;
      data = $urandom;
      if (scan_phase == PHASE_IDENT && $urandom_range(0, 99) < absent_pct)
         data[15:0] = VENDOR_ABSENT;
      return data;
   endfunction

   // drive one input beat, wait for it to be taken, then predict
   // ready is sampled between edges, where it is stable
   task automatic send_beat(input logic cmd, input logic [31:0] data);
      int gap;
      bit taken;
      gap = pick_gap();
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.read_data <= data;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      item_count++;
      predict_enumeration(cmd, data);
   endtask

   task automatic send_predicted(input logic cmd, input logic [31:0] data);
      send_beat(cmd, data);
      foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         failed = 1'b1;
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   // result side: beat-by-beat comparison, sampled between edges
   always @(negedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind = kind_type'(rsp.kind);
         got.config_address = rsp.config_address;
         got.bus_number = rsp.bus_number;
         got.slot_number = rsp.slot_number;
         got.function_number = rsp.function_number;
         got.vendor_ident = rsp.vendor_ident;
         got.device_ident = rsp.device_ident;
         got.class_value = rsp.class_value;
         got.subclass_value = rsp.subclass_value;
         got.interface_value = rsp.interface_value;
         got.header_value = rsp.header_value;
         got.last = rsp.last;
         if (awaited_beats.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $error("result beat with nothing expected, kind %0d", got.kind);
         end else begin
            want = awaited_beats.pop_front();
            check_field("kind", 32'(want.kind), 32'(got.kind));
            check_field("config_address", want.config_address, got.config_address);
            check_field("bus_number", 32'(want.bus_number), 32'(got.bus_number));
            check_field("slot_number", 32'(want.slot_number), 32'(got.slot_number));
            check_field("function_number", 32'(want.function_number),
                        32'(got.function_number));
            check_field("vendor_ident", 32'(want.vendor_ident), 32'(got.vendor_ident));
            check_field("device_ident", 32'(want.device_ident), 32'(got.device_ident));
            check_field("class_value", 32'(want.class_value), 32'(got.class_value));
            check_field("subclass_value", 32'(want.subclass_value),
                        32'(got.subclass_value));
            check_field("interface_value", 32'(want.interface_value),
                        32'(got.interface_value));
            check_field("header_value", 32'(want.header_value), 32'(got.header_value));
            check_field("last", 32'(want.last), 32'(got.last));
         end
      end
   end

   // result side: random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // watchdog: cycles with no beat taken on either side
   always @(negedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      row_type row;
      result_type typed;
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = CMD_START;
      req.read_data = '0;
      rsp.ready = 1'b0;
      scan_busy = 1'b0;
      scan_bus = '0;
      scan_slot = '0;
      scan_func = '0;
      scan_phase = PHASE_IDENT;
      scan_multi = 1'b0;
      held_ident = '0;
      held_header = '0;
      failed = 1'b0;
      calm = 1'b0;
      mismatch_count = 0;
      item_count = 0;
      quiet_cycles = 0;
      stall_left = 0;

      directed_rows = '{
         // completions with no scan running are dropped
         '{CHECK_NONE,    CMD_COMPLETE, 32'h0000_0000, 32'h0},
         '{CHECK_NONE,    CMD_COMPLETE, 32'hFFFF_FFFF, 32'h0},
         // start ignores its data
         '{CHECK_REQUEST, CMD_START,    32'hDEAD_BEEF, 32'h8000_0000},
         // function 0 present and multi-function
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h1234_8086, 32'h8000_000C},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h0080_0000, 32'h8000_0008},
         '{CHECK_PREDICT, CMD_COMPLETE, 32'h0C03_3000, 32'h0},
         // absent higher function moves on to the next one
         '{CHECK_REQUEST, CMD_COMPLETE, 32'hFFFF_FFFF, 32'h8000_0200},
         // vendor zero is present, all-ones header and class
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h0000_0000, 32'h8000_020C},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'hFFFF_FFFF, 32'h8000_0208},
         '{CHECK_PREDICT, CMD_COMPLETE, 32'hFFFF_FFFF, 32'h0},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h0000_FFFF, 32'h8000_0400},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'hFFFF_FFFE, 32'h8000_040C},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h0000_0000, 32'h8000_0408},
         '{CHECK_PREDICT, CMD_COMPLETE, 32'h0000_0000, 32'h0},
         // restart mid-scan
         '{CHECK_REQUEST, CMD_START,    32'h0000_0000, 32'h8000_0000},
         // absent function 0 skips the slot
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h0000_FFFF, 32'h8000_0800},
         // single-function slot
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h5678_1AF4, 32'h8000_080C},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'h007F_0000, 32'h8000_0808},
         '{CHECK_PREDICT, CMD_COMPLETE, 32'h0102_0300, 32'h0},
         '{CHECK_REQUEST, CMD_COMPLETE, 32'hFFFF_FFFF, 32'h8000_1800},
         '{CHECK_REQUEST, CMD_START,    32'h1111_1111, 32'h8000_0000}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.cmd, row.read_data);
         case (row.check)
            CHECK_NONE: ;
            CHECK_REQUEST: begin
               typed = '0;
               typed.kind = KIND_REQUEST;
               typed.config_address = row.address;
               typed.last = 1'b1;
               awaited_beats.push_back(typed);
            end
            default: foreach (step_beats[k]) awaited_beats.push_back(step_beats[k]);
         endcase
      end

      // restarted scans with random content and stray restarts
      while (item_count < RESTART_ITEMS) begin
         send_predicted(CMD_START, $urandom);
         repeat ($urandom_range(10, 120)) begin
            if ($urandom_range(0, 49) == 0) send_predicted(CMD_START, $urandom);
            else send_predicted(CMD_COMPLETE, pick_data(40));
         end
      end

      // a few trailing completions
      repeat (4) send_predicted(CMD_COMPLETE, $urandom);
      req.valid <= 1'b0;

      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
